[rtl/core/i2cms_pkg.sv]
// shared types and constants of the i2c master byte sequencer
`timescale 1ns / 1ps
package i2cms_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int TICK_W        = 16;
    localparam int SEG_IDX_W     = 5;

    localparam logic [2:0] MODE_START    = 3'd0;
    localparam logic [2:0] MODE_STOP     = 3'd1;
    localparam logic [2:0] MODE_WRITE    = 3'd2;
    localparam logic [2:0] MODE_READ     = 3'd3;
    localparam logic [2:0] MODE_SEND_ACK = 3'd4;
    localparam logic [2:0] MODE_RECV_ACK = 3'd5;

    localparam logic [TICK_W-1:0] TICKS_RESET = 16'd11;

    typedef struct packed {
        logic [2:0]               mode;
        logic [BITS_PER_BYTE-1:0] write_byte;
        logic                     ack_to_send;
        logic [BITS_PER_BYTE-1:0] sampled_bits;
    } cmd_t;

    typedef struct packed {
        logic                     scl_level;
        logic                     sda_level;
        logic [1:0]               hold_units;
        logic [BITS_PER_BYTE-1:0] read_byte;
        logic                     ack_seen;
        logic                     last;
    } seg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_WAIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic emit;
        logic start_wait;
        logic run_wait;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic mode_ok;
        logic seg_last;
        logic out_free;
        logic wait_done;
    } dp_stat_t;

endpackage

[rtl/core/i2c_master_byte_sequencer_unit.sv]
// top level of the i2c master byte sequencer
`timescale 1ns / 1ps
// Byte-level i2c master sequencer. Each command item (start, stop, write byte,
// read byte, send ack, receive ack) turns into a run of waveform segment items
// giving scl level, sda level (1 = released) and a hold time of 0..3 delay
// units; the final segment has last set and carries the read byte or the
// ack flag. Commands are processed one at a time: a command is taken only
// while the sequencer is idle, then each segment is written to the output
// register and followed by its hold time, counted down by the datapath timer
// in delay units of ticks_per_unit (a tick value of zero counts as one). A
// command yields 3, 4 or 18 segments, and a segment is emitted only once the
// output register is free, so an output stall holds it back. Mode codes 6 and
// 7 are taken and dropped with no segments. The output register lets the next
// command be taken while the final segment still waits on the output side.
// ticks_per_unit resets to 11 and must only be written while the sequencer is
// idle.
module i2c_master_byte_sequencer_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    // command items
    input  logic                         cmd_valid,
    output logic                         cmd_stall,
    input  i2cms_pkg::cmd_t              cmd,
    // segment items
    output logic                         seg_valid,
    input  logic                         seg_stall,
    output i2cms_pkg::seg_t              seg,
    // ticks_per_unit register write
    input  logic                         cfg_write,
    input  logic [i2cms_pkg::TICK_W-1:0] cfg_data
);
    import i2cms_pkg::*;

    dp_cmd_t  ctl;
    dp_stat_t stat;

    // sequencing: idle, emit segment, hold timer
    i2cms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .stat      (stat),
        .ctl       (ctl)
    );

    // command registers, segment builder, output register and timer
    i2cms_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .seg_valid (seg_valid),
        .seg_stall (seg_stall),
        .seg       (seg),
        .ctl       (ctl),
        .stat      (stat)
    );

endmodule

[rtl/core/i2cms_ctrl.sv]
// controller state machine of the i2c master byte sequencer
`timescale 1ns / 1ps
module i2cms_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  i2cms_pkg::dp_stat_t stat,
    output i2cms_pkg::dp_cmd_t  ctl
);
    import i2cms_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_stall  = 1'b1;
        ctl        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd_stall = 1'b0;
                // unknown modes are taken and dropped
                if (cmd_valid && stat.mode_ok)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    ctl.emit = 1'b1;
                    if (stat.seg_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ctl.start_wait = 1'b1;
                        state_next     = ST_WAIT;
                    end
                end
            end
            ST_WAIT:
            begin
                ctl.run_wait = 1'b1;
                if (stat.wait_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/i2cms_dp.sv]
// datapath of the i2c master byte sequencer: command regs, segment build, timer
`timescale 1ns / 1ps
module i2cms_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  i2cms_pkg::cmd_t                   cmd,
    input  logic                              cfg_write,
    input  logic [i2cms_pkg::TICK_W-1:0]      cfg_data,
    output logic                              seg_valid,
    input  logic                              seg_stall,
    output i2cms_pkg::seg_t                   seg,
    input  i2cms_pkg::dp_cmd_t                ctl,
    output i2cms_pkg::dp_stat_t               stat
);
    import i2cms_pkg::*;

    cmd_t                     cmd_reg;
    logic [BITS_PER_BYTE-1:0] shift_reg;
    logic [SEG_IDX_W-1:0]     idx_reg;
    seg_t                     seg_reg;
    logic                     seg_valid_reg;
    logic [TICK_W-1:0]        tpu_reg;
    logic [TICK_W-1:0]        tick_reg;
    logic [1:0]               units_reg;
    seg_t                     cur;
    logic                     bit_now;
    logic                     nack;

    assign bit_now = shift_reg[BITS_PER_BYTE-1];
    assign nack    = ~cmd_reg.ack_to_send;

    // segment for the current index
    always_comb
    begin
        cur = '0;
        case (cmd_reg.mode)
            MODE_START:
            begin
                case (idx_reg)
                    5'd0:    cur = '{1'b1, 1'b1, 2'd3, '0, 1'b0, 1'b0};
                    5'd1:    cur = '{1'b1, 1'b0, 2'd3, '0, 1'b0, 1'b0};
                    default: cur = '{1'b0, 1'b0, 2'd0, '0, 1'b0, 1'b1};
                endcase
            end
            MODE_STOP:
            begin
                case (idx_reg)
                    5'd0:    cur = '{1'b0, 1'b0, 2'd3, '0, 1'b0, 1'b0};
                    5'd1:    cur = '{1'b1, 1'b0, 2'd3, '0, 1'b0, 1'b0};
                    default: cur = '{1'b1, 1'b1, 2'd0, '0, 1'b0, 1'b1};
                endcase
            end
            MODE_WRITE:
            begin
                if (idx_reg == '0)
                begin
                    cur = '{1'b0, 1'b0, 2'd2, '0, 1'b0, 1'b0};
                end
                else if (idx_reg >= 5'd17)
                begin
                    cur = '{1'b0, 1'b1, 2'd0, '0, 1'b0, 1'b1};
                end
                else if (idx_reg[0])
                begin
                    cur = '{1'b0, bit_now, 2'd2, '0, 1'b0, 1'b0};
                end
                else
                begin
                    cur = '{1'b1, bit_now, 2'd3, '0, 1'b0, 1'b0};
                end
            end
            MODE_READ:
            begin
                if (idx_reg == '0)
                begin
                    cur = '{1'b0, 1'b1, 2'd3, '0, 1'b0, 1'b0};
                end
                else if (idx_reg >= 5'd17)
                begin
                    // sampled bits arrive msb first, so the byte is them as is
                    cur = '{1'b0, 1'b1, 2'd0, cmd_reg.sampled_bits, 1'b0, 1'b1};
                end
                else if (idx_reg[0])
                begin
                    cur = '{1'b1, 1'b1, 2'd3, '0, 1'b0, 1'b0};
                end
                else
                begin
                    cur = '{1'b0, 1'b1, 2'd2, '0, 1'b0, 1'b0};
                end
            end
            MODE_SEND_ACK:
            begin
                case (idx_reg)
                    5'd0:    cur = '{1'b0, 1'b0, 2'd1, '0, 1'b0, 1'b0};
                    5'd1:    cur = '{1'b0, nack, 2'd1, '0, 1'b0, 1'b0};
                    5'd2:    cur = '{1'b1, nack, 2'd2, '0, 1'b0, 1'b0};
                    default: cur = '{1'b0, 1'b1, 2'd0, '0, 1'b0, 1'b1};
                endcase
            end
            MODE_RECV_ACK:
            begin
                // sda stays released through the whole ack phase
                case (idx_reg)
                    5'd0:    cur = '{1'b0, 1'b1, 2'd1, '0, 1'b0, 1'b0};
                    5'd1:    cur = '{1'b1, 1'b1, 2'd1, '0, 1'b0, 1'b0};
                    default: cur = '{1'b0, 1'b1, 2'd0, '0,
                                     ~cmd_reg.sampled_bits[BITS_PER_BYTE-1], 1'b1};
                endcase
            end
            default:
            begin
                cur = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg   <= cmd;
            shift_reg <= cmd.write_byte;
        end
        else if (ctl.emit && cmd_reg.mode == MODE_WRITE && idx_reg != '0 && !idx_reg[0])
        begin
            // next bit after the scl high segment
            shift_reg <= {shift_reg[BITS_PER_BYTE-2:0], 1'b0};
        end
        if (ctl.emit)
        begin
            seg_reg <= cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            seg_valid_reg <= 1'b0;
            tpu_reg       <= TICKS_RESET;
            tick_reg      <= '0;
            units_reg     <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                tpu_reg <= cfg_data;
            end
            if (ctl.load)
            begin
                idx_reg <= '0;
            end
            else if (ctl.emit)
            begin
                idx_reg <= idx_reg + 5'd1;
            end
            if (ctl.emit)
            begin
                seg_valid_reg <= 1'b1;
            end
            else if (!seg_stall)
            begin
                seg_valid_reg <= 1'b0;
            end
            if (ctl.start_wait)
            begin
                units_reg <= cur.hold_units;
                tick_reg  <= tpu_reg;
            end
            else if (ctl.run_wait && units_reg != '0)
            begin
                // a zero tick count acts as one tick per unit
                if (tick_reg <= 16'd1)
                begin
                    units_reg <= units_reg - 2'd1;
                    tick_reg  <= tpu_reg;
                end
                else
                begin
                    tick_reg <= tick_reg - 16'd1;
                end
            end
        end
    end

    assign seg_valid      = seg_valid_reg;
    assign seg            = seg_reg;
    assign stat.mode_ok   = (cmd.mode <= MODE_RECV_ACK);
    assign stat.seg_last  = cur.last;
    assign stat.out_free  = !seg_valid_reg || !seg_stall;
    assign stat.wait_done = (units_reg == '0);

endmodule
